@@ hdl/awa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awa_pkg
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package awa_pkg;

    localparam int ZW   = 40;   // rotation-angle width, Q32
    localparam int RW   = 33;   // rotation x/y width, Q30
    localparam int PW   = 50;   // product width
    localparam int DW   = 51;   // denominator width
    localparam int VW   = 54;   // vectoring x/y width
    localparam int AW   = 36;   // vectoring angle width, Q32
    localparam int TABLE_LEN = 24;

    localparam logic signed [ZW-1:0] HALF_PI_Q32  = 40'sd6746518852;
    localparam logic signed [RW-1:0] INV_GAIN_Q30 = 33'sd652032875;

    localparam logic [1:0] REG_WHEELBASE = 2'd0;
    localparam logic [1:0] REG_TRACK     = 2'd1;
    localparam logic [1:0] REG_DISABLED  = 2'd2;

    localparam logic signed [AW-1:0] ATAN_Q32 [TABLE_LEN] = '{
        36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
        36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
        36'sd16777131,   36'sd8388597,    36'sd4194303,    36'sd2097152,
        36'sd1048576,    36'sd524288,     36'sd262144,     36'sd131072,
        36'sd65536,      36'sd32768,      36'sd16384,      36'sd8192,
        36'sd4096,       36'sd2048,       36'sd1024,       36'sd512
    };

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } rot_t;

    typedef struct packed {
        logic signed [PW-1:0] n;
        logic signed [PW-1:0] lc;
        logic signed [PW-1:0] hws;
        logic                 c_neg;
    } mul_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] z;
        logic                 zero;   // denominator was zero, spec holds result
        logic signed [AW-1:0] spec;
    } lane_t;

    typedef struct packed {
        lane_t inner;
        lane_t outer;
        logic  deg;
    } vec_t;

endpackage
`default_nettype wire

@@ hdl/awa_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awa_if
// Command and result channels, valid/ready per beat.
// ----------------------------------------------------------------------------
interface awa_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] steer_angle;
    modport source (output valid, output steer_angle, input ready);
    modport sink   (input valid, input steer_angle, output ready);
endinterface

interface awa_res_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] inner_angle;
    logic signed [14:0] outer_angle;
    logic               degenerate;
    modport source (output valid, output inner_angle, output outer_angle,
                    output degenerate, input ready);
    modport sink   (input valid, input inner_angle, input outer_angle,
                    input degenerate, output ready);
endinterface
`default_nettype wire

@@ hdl/ackermann_wheel_angles.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ackermann_wheel_angles
// Inner and outer front wheel angles from a central steering command.
// ----------------------------------------------------------------------------
// One command beat in, one result beat out, a new command every cycle unless
// the sink stalls. The pipeline is made of a fold register, a row of
// CORDIC_STAGES rotation cells giving sin and cos, one multiply register
// (L*s, L*c, W*s/2), one denominator register, a row of CORDIC_STAGES
// vectoring cells running both wheels side by side, and the output register.
// The whole row advances whenever the output register is empty or being
// taken, so a stalled sink holds every stage in place. With disabled set,
// commands are still taken but produce no result. The user must write
// configuration only while the pipeline is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module ackermann_wheel_angles
    import awa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    awa_cmd_if.sink     cmd,
    awa_res_if.source   res,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    localparam int SH = 32 - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] RND_Z = 40'sd1 <<< (31 - ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] HP_Z  = (HALF_PI_Q32 + RND_Z) >>> SH;
    localparam logic signed [AW-1:0] HP    = AW'(HP_Z);
    localparam logic signed [AW-1:0] RND   = AW'(RND_Z);

    // configuration
    logic [15:0] wheelbase_reg, track_reg;
    logic        disabled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheelbase_reg <= 16'd2000;
            track_reg     <= 16'd1500;
            disabled_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WHEELBASE: wheelbase_reg <= cfg_data;
                REG_TRACK:     track_reg     <= cfg_data;
                REG_DISABLED:  disabled_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // global advance: output slot free or draining
    logic out_vld_reg;
    logic adv;
    assign adv       = !out_vld_reg || res.ready;
    assign cmd.ready = adv;

    // fold stage: angles past +-pi/2 mirror to +-pi - a, cos negated later
    logic                 fold_vld_reg;
    rot_t                 fold_reg, fold_next;
    logic signed [ZW-1:0] z_in;

    always_comb
    begin
        z_in = {{(ZW-15){cmd.steer_angle[14]}}, cmd.steer_angle} <<< SH;
        fold_next.x    = INV_GAIN_Q30;
        fold_next.y    = '0;
        fold_next.z    = z_in;
        fold_next.flip = 1'b0;
        if (z_in > HALF_PI_Q32)
        begin
            fold_next.z    = (HALF_PI_Q32 <<< 1) - z_in;
            fold_next.flip = 1'b1;
        end
        else if (z_in < -HALF_PI_Q32)
        begin
            fold_next.z    = -(HALF_PI_Q32 <<< 1) - z_in;
            fold_next.flip = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_vld_reg <= 1'b0;
        else if (adv)
            fold_vld_reg <= cmd.valid && !disabled_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            fold_reg <= fold_next;
    end

    // rotation row: sin/cos
    logic rv [CORDIC_STAGES+1];
    rot_t rd [CORDIC_STAGES+1];
    assign rv[0] = fold_vld_reg;
    assign rd[0] = fold_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_rot
        awa_rot_cell #(.SHIFT(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .vld_i(rv[g]), .d_i(rd[g]), .vld_o(rv[g+1]), .d_o(rd[g+1])
        );
    end

    // multiply stage: N = L*s, L*c, (W*s)/2 rounded toward -inf
    logic                 mul_vld_reg;
    mul_t                 mul_reg, mul_next;
    logic signed [RW-1:0] cos_v, sin_v;
    logic signed [PW-1:0] ws;

    always_comb
    begin
        sin_v            = rd[CORDIC_STAGES].y;
        cos_v            = rd[CORDIC_STAGES].flip ? -rd[CORDIC_STAGES].x
                                                  : rd[CORDIC_STAGES].x;
        mul_next.n       = $signed({1'b0, wheelbase_reg}) * sin_v;
        mul_next.lc      = $signed({1'b0, wheelbase_reg}) * cos_v;
        ws               = $signed({1'b0, track_reg}) * sin_v;
        mul_next.hws     = ws >>> 1;
        mul_next.c_neg   = cos_v < 0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else if (adv)
            mul_vld_reg <= rv[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            mul_reg <= mul_next;
    end

    // denominator stage: set up both vectoring lanes
    logic                 den_vld_reg;
    vec_t                 den_reg, den_next;
    logic signed [DW-1:0] den_i, den_o;

    function automatic lane_t setup(logic signed [DW-1:0] den,
                                    logic signed [PW-1:0] num, logic c_neg);
        lane_t l;
        logic signed [VW-1:0] dx, ny;
        dx     = VW'(den);
        ny     = VW'(num);
        l.x    = (den < 0) ? -dx : dx;
        l.y    = (den < 0) ? -ny : ny;
        l.z    = '0;
        l.zero = (den == 0);
        if (num == 0)
            l.spec = '0;
        else
            l.spec = ((num > 0) != c_neg) ? HP : -HP;
        return l;
    endfunction

    always_comb
    begin
        den_i = DW'(mul_reg.lc) - DW'(mul_reg.hws);
        den_o = DW'(mul_reg.lc) + DW'(mul_reg.hws);
        den_next.inner = setup(den_i, mul_reg.n, mul_reg.c_neg);
        den_next.outer = setup(den_o, mul_reg.n, mul_reg.c_neg);
        den_next.deg   = (den_i == 0) || ((den_i < 0) != mul_reg.c_neg)
                      || (den_o == 0) || ((den_o < 0) != mul_reg.c_neg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            den_vld_reg <= 1'b0;
        else if (adv)
            den_vld_reg <= mul_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            den_reg <= den_next;
    end

    // vectoring row: atan(N/D) for both wheels
    logic vv [CORDIC_STAGES+1];
    vec_t vd [CORDIC_STAGES+1];
    assign vv[0] = den_vld_reg;
    assign vd[0] = den_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_vec
        awa_vec_cell #(.SHIFT(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(adv),
            .vld_i(vv[g]), .d_i(vd[g]), .vld_o(vv[g+1]), .d_o(vd[g+1])
        );
    end

    // output stage: round half up, clamp, pick zero-denominator answer
    logic signed [14:0] inner_reg, outer_reg, inner_next, outer_next;
    logic               deg_reg;

    function automatic logic signed [14:0] finish(lane_t l);
        logic signed [AW-1:0] r;
        r = (l.z + RND) >>> SH;
        if (r > HP)
            r = HP;
        if (r < -HP)
            r = -HP;
        if (l.zero)
            r = l.spec;
        return r[14:0];
    endfunction

    assign inner_next = finish(vd[CORDIC_STAGES].inner);
    assign outer_next = finish(vd[CORDIC_STAGES].outer);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vv[CORDIC_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            inner_reg <= inner_next;
            outer_reg <= outer_next;
            deg_reg   <= vd[CORDIC_STAGES].deg;
        end
    end

    assign res.valid       = out_vld_reg;
    assign res.inner_angle = inner_reg;
    assign res.outer_angle = outer_reg;
    assign res.degenerate  = deg_reg;

    // a stall freezes the row
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(fold_vld_reg) && $stable(mul_vld_reg) && $stable(den_vld_reg))
        else $error("pipeline moved during stall");

    // a command taken while disabled never enters the row
    a_disabled_drop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready && disabled_reg |=> !fold_vld_reg)
        else $error("command entered while disabled");

    // a result appears only from the last vectoring cell
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(vv[CORDIC_STAGES]))
        else $error("result without a source");
endmodule
`default_nettype wire

@@ hdl/awa_rot_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awa_rot_cell
// One rotation-mode CORDIC micro-rotation with its pipeline register.
// ----------------------------------------------------------------------------
module awa_rot_cell
    import awa_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  en,
    input  wire  vld_i,
    input  rot_t d_i,
    output logic vld_o,
    output rot_t d_o
);
    logic vld_reg;
    rot_t d_reg, d_next;

    always_comb
    begin
        d_next = d_i;
        if (d_i.z >= 0)
        begin
            d_next.x = d_i.x - (d_i.y >>> SHIFT);
            d_next.y = d_i.y + (d_i.x >>> SHIFT);
            d_next.z = d_i.z - ZW'(ATAN_Q32[SHIFT]);
        end
        else
        begin
            d_next.x = d_i.x + (d_i.y >>> SHIFT);
            d_next.y = d_i.y - (d_i.x >>> SHIFT);
            d_next.z = d_i.z + ZW'(ATAN_Q32[SHIFT]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vld_o = vld_reg;
    assign d_o   = d_reg;
endmodule
`default_nettype wire

@@ hdl/awa_vec_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awa_vec_cell
// One vectoring-mode CORDIC step for the inner and outer lanes.
// ----------------------------------------------------------------------------
module awa_vec_cell
    import awa_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  en,
    input  wire  vld_i,
    input  vec_t d_i,
    output logic vld_o,
    output vec_t d_o
);
    logic vld_reg;
    vec_t d_reg, d_next;

    function automatic lane_t step(lane_t l);
        lane_t r;
        r = l;
        if (l.y >= 0)
        begin
            r.x = l.x + (l.y >>> SHIFT);
            r.y = l.y - (l.x >>> SHIFT);
            r.z = l.z + ATAN_Q32[SHIFT];
        end
        else
        begin
            r.x = l.x - (l.y >>> SHIFT);
            r.y = l.y + (l.x >>> SHIFT);
            r.z = l.z - ATAN_Q32[SHIFT];
        end
        return r;
    endfunction

    always_comb
    begin
        d_next       = d_i;
        d_next.inner = step(d_i.inner);
        d_next.outer = step(d_i.outer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vld_o = vld_reg;
    assign d_o   = d_reg;
endmodule
`default_nettype wire
